// ===== design/dfd_pkg.sv =====
// Shared types and constants for the deadlock cycle detector.
package dfd_pkg;

  localparam int MASK_W     = 16;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESOURCE_COUNT = 1'b1;

  typedef struct packed {
    logic              last_row;
    logic [MASK_W-1:0] alloc_mask;
    logic [MASK_W-1:0] request_mask;
    logic [INDEX_W-1:0] process_index;
  } row_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_STEP,
    ST_RESUME,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic searching;
    logic done;
  } back_stat_t;

endpackage

// ===== design/dfd_front.sv =====
// Input side: unpacks row words and queues them for the search engine.
module dfd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dfd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  output logic                              q_valid,
  input  logic                              q_ready,
  output dfd_pkg::row_word_t                q_word
);

  dfd_pkg::row_word_t                 mem_r [dfd_pkg::QUEUE_DEPTH];
  logic [dfd_pkg::QUEUE_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dfd_pkg::QUEUE_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dfd_pkg::QUEUE_AW:0]         count_r, count_nxt;
  dfd_pkg::row_word_t                 in_word;
  logic                               push, pop;

  always_comb begin
    in_word.process_index = in_tdata[dfd_pkg::INDEX_W-1:0];
    in_word.request_mask  = in_tdata[dfd_pkg::INDEX_W +: dfd_pkg::MASK_W];
    in_word.alloc_mask    = in_tdata[dfd_pkg::INDEX_W + dfd_pkg::MASK_W +: dfd_pkg::MASK_W];
    in_word.last_row      = in_tlast;
  end

  assign in_tready = (count_r != (dfd_pkg::QUEUE_AW+1)'(dfd_pkg::QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_word    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (dfd_pkg::QUEUE_AW+1)'(push) - (dfd_pkg::QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_word;
    end
  end

endmodule

// ===== design/dfd_back.sv =====
// Search engine: holds the matrices and walks the graph depth first.
module dfd_back #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dfd_pkg::COUNT_W-1:0]       proc_cnt,
  input  logic [dfd_pkg::COUNT_W-1:0]       res_cnt,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  dfd_pkg::row_word_t                q_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              deadlock,
  output dfd_pkg::back_stat_t               stat
);

  localparam int MAXV = MAX_PROCESSES + MAX_RESOURCES;
  localparam int VW   = $clog2(MAXV);
  localparam int VCW  = $clog2(MAXV + 1);
  localparam int ROWS = (MAX_PROCESSES < dfd_pkg::MASK_W) ? MAX_PROCESSES : dfd_pkg::MASK_W;

  dfd_pkg::state_t              state_r, state_nxt;
  logic [dfd_pkg::MASK_W-1:0]   req_rows_r   [ROWS];
  logic [dfd_pkg::MASK_W-1:0]   alloc_rows_r [ROWS];
  logic [ROWS-1:0]              row_vld_r, row_vld_nxt;
  logic [VCW-1:0]               np_r, np_nxt, nr_r, nr_nxt, total;
  logic [MAXV-1:0]              visited_r, visited_nxt, onpath_r, onpath_nxt;
  logic [VW-1:0]                cur_r, cur_nxt, anc_r, anc_nxt;
  logic                         found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt, out_data_r, out_data_nxt;
  logic [VW-1:0]                stk_mem [MAXV];
  logic [VW-1:0]                stk_rd_r;
  logic                         stk_we, stk_re;
  logic [VW-1:0]                stk_raddr;

  logic                         pop, row_we;
  logic [VCW-1:0]               np_clamp, nr_clamp;
  logic [dfd_pkg::MASK_W-1:0]   rmask, req_sel;
  logic [VW-1:0]                res_idx;
  logic                         is_proc;
  logic [MAXV-1:0]              req_ext, col, nbr, fresh, unv, totmask;
  logic                         back_edge;
  logic [VW-1:0]                pick, root;

  always_comb begin
    if (proc_cnt == '0) begin
      np_clamp = VCW'(1);
    end else if (int'(proc_cnt) > MAX_PROCESSES) begin
      np_clamp = VCW'(MAX_PROCESSES);
    end else begin
      np_clamp = VCW'(proc_cnt);
    end
    if (res_cnt == '0) begin
      nr_clamp = VCW'(1);
    end else if (int'(res_cnt) > MAX_RESOURCES) begin
      nr_clamp = VCW'(MAX_RESOURCES);
    end else begin
      nr_clamp = VCW'(res_cnt);
    end
  end

  assign total = np_r + nr_r;

  always_comb begin
    for (int j = 0; j < dfd_pkg::MASK_W; j++) begin
      rmask[j] = (j < int'(nr_r));
    end
    for (int w = 0; w < MAXV; w++) begin
      totmask[w] = (w < int'(total));
    end
  end

  always_comb begin
    is_proc = ({1'b0, cur_r} < (VW+1)'(np_r));
    res_idx = cur_r - VW'(np_r);
    req_sel = '0;
    col     = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (cur_r == VW'(i) && row_vld_r[i]) begin
        req_sel = req_rows_r[i];
      end
      col[i] = row_vld_r[i] && (i < int'(np_r)) &&
               (|(alloc_rows_r[i] & rmask & (dfd_pkg::MASK_W'(1) << res_idx)));
    end
    req_ext   = MAXV'(req_sel & rmask);
    nbr       = is_proc ? (req_ext << np_r) : col;
    back_edge = |(nbr & onpath_r);
    fresh     = nbr & ~visited_r;
    unv       = ~visited_r & totmask;
  end

  always_comb begin
    pick = '0;
    root = '0;
    for (int i = MAXV - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        pick = VW'(i);
      end
      if (unv[i]) begin
        root = VW'(i);
      end
    end
  end

  assign pop    = q_valid && q_ready;
  assign row_we = pop && (int'(q_word.process_index) < ROWS);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfd_pkg::ST_IDLE: begin
        if (pop && q_word.last_row) begin
          state_nxt = dfd_pkg::ST_ROOT;
        end
      end
      dfd_pkg::ST_ROOT: begin
        state_nxt = (unv == '0) ? dfd_pkg::ST_DONE : dfd_pkg::ST_STEP;
      end
      dfd_pkg::ST_STEP: begin
        priority if (back_edge) begin
          state_nxt = dfd_pkg::ST_DONE;
        end else if (fresh != '0) begin
          state_nxt = dfd_pkg::ST_STEP;
        end else if (anc_r == '0) begin
          state_nxt = dfd_pkg::ST_ROOT;
        end else begin
          state_nxt = dfd_pkg::ST_RESUME;
        end
      end
      dfd_pkg::ST_RESUME: state_nxt = dfd_pkg::ST_STEP;
      dfd_pkg::ST_DONE: begin
        if (!out_valid_r) begin
          state_nxt = dfd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready       = 1'b0;
    np_nxt        = np_r;
    nr_nxt        = nr_r;
    visited_nxt   = visited_r;
    onpath_nxt    = onpath_r;
    cur_nxt       = cur_r;
    anc_nxt       = anc_r;
    found_nxt     = found_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    stk_raddr     = anc_r - 1'b1;
    unique case (state_r)
      dfd_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        for (int i = 0; i < ROWS; i++) begin
          if (row_we && q_word.process_index == dfd_pkg::INDEX_W'(i)) begin
            row_vld_nxt[i] = 1'b1;
          end
        end
        if (pop && q_word.last_row) begin
          np_nxt      = np_clamp;
          nr_nxt      = nr_clamp;
          visited_nxt = '0;
          onpath_nxt  = '0;
          found_nxt   = 1'b0;
        end
      end
      dfd_pkg::ST_ROOT: begin
        if (unv != '0) begin
          cur_nxt     = root;
          visited_nxt = visited_r | (MAXV'(1) << root);
          onpath_nxt  = onpath_r | (MAXV'(1) << root);
          anc_nxt     = '0;
        end
      end
      dfd_pkg::ST_STEP: begin
        priority if (back_edge) begin
          found_nxt = 1'b1;
        end else if (fresh != '0) begin
          stk_we      = 1'b1;
          anc_nxt     = anc_r + 1'b1;
          cur_nxt     = pick;
          visited_nxt = visited_r | (MAXV'(1) << pick);
          onpath_nxt  = onpath_r | (MAXV'(1) << pick);
        end else begin
          onpath_nxt = onpath_r & ~(MAXV'(1) << cur_r);
          if (anc_r != '0) begin
            stk_re  = 1'b1;
            anc_nxt = anc_r - 1'b1;
          end
        end
      end
      dfd_pkg::ST_RESUME: cur_nxt = stk_rd_r;
      dfd_pkg::ST_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = found_r;
          row_vld_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfd_pkg::ST_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      visited_r   <= '0;
      onpath_r    <= '0;
      anc_r       <= '0;
      found_r     <= 1'b0;
      np_r        <= VCW'(1);
      nr_r        <= VCW'(1);
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      visited_r   <= visited_nxt;
      onpath_r    <= onpath_nxt;
      anc_r       <= anc_nxt;
      found_r     <= found_nxt;
      np_r        <= np_nxt;
      nr_r        <= nr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < ROWS; i++) begin
      if (row_we && q_word.process_index == dfd_pkg::INDEX_W'(i)) begin
        req_rows_r[i]   <= q_word.request_mask;
        alloc_rows_r[i] <= q_word.alloc_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[anc_r] <= cur_r;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  assign out_valid      = out_valid_r;
  assign deadlock       = out_data_r;
  assign stat.idle      = (state_r == dfd_pkg::ST_IDLE);
  assign stat.searching = (state_r == dfd_pkg::ST_ROOT) || (state_r == dfd_pkg::ST_STEP) ||
                          (state_r == dfd_pkg::ST_RESUME);
  assign stat.done      = (state_r == dfd_pkg::ST_DONE);

endmodule

// ===== design/deadlock_cycle_detector.sv =====
// Top level of the deadlock cycle detector: config registers, queue and search engine.
// Each input word stores one process row (request and allocation masks);
// a word with tlast set stores its row and then starts a depth-first cycle search over
// all P+R process and resource vertices, after which one word carries the deadlock flag
// and the stored rows are cleared. The search sequencer takes one step per cycle: it
// picks each new root in ROOT, pushes each new vertex in STEP and pops a vertex in STEP
// and then RESUME (the stack memory read is registered), and it ends early at the first
// back edge. A four-word queue keeps accepting rows while the search runs, and the result
// sits in an output register until taken.
module deadlock_cycle_detector #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dfd_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] process_index, [19:4] request_mask, [35:20] alloc_mask, [39:36] zero
  input  logic [dfd_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] deadlock, [7:1] zero
  output logic [dfd_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic [dfd_pkg::COUNT_W-1:0] proc_cnt_r, proc_cnt_nxt;
  logic [dfd_pkg::COUNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                        q_valid, q_ready;
  dfd_pkg::row_word_t          q_word;
  logic                        deadlock;
  dfd_pkg::back_stat_t         stat;

  always_comb begin
    proc_cnt_nxt = proc_cnt_r;
    res_cnt_nxt  = res_cnt_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        dfd_pkg::CFG_PROCESS_COUNT:  proc_cnt_nxt = cfg_wdata;
        dfd_pkg::CFG_RESOURCE_COUNT: res_cnt_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_cnt_r <= dfd_pkg::COUNT_W'(16);
      res_cnt_r  <= dfd_pkg::COUNT_W'(16);
    end else begin
      proc_cnt_r <= proc_cnt_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
  end

  dfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_word    (q_word)
  );

  dfd_back #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc_cnt  (proc_cnt_r),
    .res_cnt   (res_cnt_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_word    (q_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .deadlock  (deadlock),
    .stat      (stat)
  );

  assign out_tdata = {(dfd_pkg::OUT_DATA_W-1)'(0), deadlock};

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(stat.done))
    else $error("result word raised without a finished search");

  a_no_row_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    stat.searching |-> !(q_valid && q_ready))
    else $error("row taken from queue during search");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> stat.idle)
    else $error("queue drained outside idle");

  a_gap_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid)
    else $error("new result word right after hand-off");

endmodule

// ===== tb/deadlock_cycle_detector_checker.sv =====
// Checker for the deadlock cycle detector: predicts each deadlock word and compares it.
module deadlock_cycle_detector_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dfd_pkg::COUNT_W-1:0]    cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [dfd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [dfd_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             flags_pending
);

  localparam int ROWS = 1 << dfd_pkg::INDEX_W;
  localparam int ROW_BITS = 2 * dfd_pkg::MASK_W + dfd_pkg::INDEX_W;

  logic [dfd_pkg::MASK_W-1:0]  request_rows [ROWS];
  logic [dfd_pkg::MASK_W-1:0]  alloc_rows [ROWS];
  logic [dfd_pkg::COUNT_W-1:0] process_count;
  logic [dfd_pkg::COUNT_W-1:0] resource_count;
  bit                          expected_flags [$];

  function automatic int clamp_count(logic [dfd_pkg::COUNT_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Peel off vertices with no edge into the remaining graph; whatever is left lies on a cycle.
  function automatic bit graph_has_cycle(int np, int nr);
    logic [dfd_pkg::MASK_W-1:0] live_res;
    logic [dfd_pkg::MASK_W-1:0] fed_res;
    logic [ROWS-1:0]            live_proc;
    bit                         changed;
    live_res = (nr >= dfd_pkg::MASK_W) ? '1 : dfd_pkg::MASK_W'((1 << nr) - 1);
    live_proc = '0;
    for (int p = 0; p < np; p++) live_proc[p] = 1'b1;
    do begin
      changed = 0;
      for (int p = 0; p < np; p++) begin
        if (live_proc[p] && (request_rows[p] & live_res) == '0) begin
          live_proc[p] = 1'b0;
          changed = 1;
        end
      end
      fed_res = '0;
      for (int p = 0; p < np; p++) begin
        if (live_proc[p]) fed_res |= alloc_rows[p];
      end
      if ((live_res & fed_res) != live_res) begin
        live_res &= fed_res;
        changed = 1;
      end
    end while (changed);
    return (live_proc != '0) || (live_res != '0);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    dfd_pkg::row_word_t row;
    bit                 want;
    if (!rst_n) begin
      process_count = dfd_pkg::COUNT_W'(ROWS);
      resource_count = dfd_pkg::COUNT_W'(dfd_pkg::MASK_W);
      foreach (request_rows[i]) begin
        request_rows[i] = '0;
        alloc_rows[i] = '0;
      end
      expected_flags.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_flags.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_tdata));
        end else begin
          want = expected_flags.pop_front();
          if (out_tdata !== dfd_pkg::OUT_DATA_W'(want))
            report_mismatch($sformatf("deadlock word %h, expected %0d", out_tdata, want));
        end
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          dfd_pkg::CFG_PROCESS_COUNT: process_count = cfg_wdata;
          dfd_pkg::CFG_RESOURCE_COUNT: resource_count = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        row = {in_tlast, in_tdata[ROW_BITS-1:0]};
        request_rows[row.process_index] = row.request_mask;
        alloc_rows[row.process_index] = row.alloc_mask;
        if (row.last_row) begin
          expected_flags.push_back(graph_has_cycle(clamp_count(process_count, ROWS),
                                                   clamp_count(resource_count,
                                                               dfd_pkg::MASK_W)));
          foreach (request_rows[i]) begin
            request_rows[i] = '0;
            alloc_rows[i] = '0;
          end
        end
      end
    end
    flags_pending = expected_flags.size();
  end

endmodule

// ===== tb/deadlock_cycle_detector_tb.sv =====
// Testbench top for the deadlock cycle detector: row stimulus, config phases and verdict.
module deadlock_cycle_detector_tb;

  typedef enum int {
    FRAME_SPARSE,
    FRAME_RING,
    FRAME_DENSE,
    FRAME_NOISE
  } frame_kind_t;

  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [dfd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [dfd_pkg::COUNT_W-1:0]    cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [dfd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [dfd_pkg::OUT_DATA_W-1:0] out_tdata;
  int                             mismatches;
  int                             flags_pending;

  int cur_procs;
  int cur_res;
  bit sender_idle;
  bit receiver_idle;
  bit hold_output;

  deadlock_cycle_detector dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  deadlock_cycle_detector_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .flags_pending(flags_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 0;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int clamp_count(logic [dfd_pkg::COUNT_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [dfd_pkg::MASK_W-1:0] sparse_mask();
    return dfd_pkg::MASK_W'($urandom & $urandom & $urandom);
  endfunction

  task automatic send_row(logic [dfd_pkg::INDEX_W-1:0] idx, logic [dfd_pkg::MASK_W-1:0] req,
                          logic [dfd_pkg::MASK_W-1:0] alloc, bit last);
    int gap;
    gap = (sender_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(dfd_pkg::IN_DATA_W - 2 * dfd_pkg::MASK_W - dfd_pkg::INDEX_W){1'b0}},
                 alloc, req, idx};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [dfd_pkg::CFG_ADDR_W-1:0] addr,
                           logic [dfd_pkg::COUNT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain all pending deadlock words and let the search engine settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (flags_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_counts(logic [dfd_pkg::COUNT_W-1:0] procs,
                            logic [dfd_pkg::COUNT_W-1:0] res);
    drain();
    write_reg(dfd_pkg::CFG_PROCESS_COUNT, procs);
    write_reg(dfd_pkg::CFG_RESOURCE_COUNT, res);
    cur_procs = clamp_count(procs, 1 << dfd_pkg::INDEX_W);
    cur_res = clamp_count(res, dfd_pkg::MASK_W);
  endtask

  task automatic run_phase(int n_items, bit short_frames);
    int                          sent;
    int                          len;
    int                          base;
    int                          ring [20];
    frame_kind_t                 kind;
    logic [dfd_pkg::INDEX_W-1:0] idx;
    logic [dfd_pkg::MASK_W-1:0]  req;
    logic [dfd_pkg::MASK_W-1:0]  alloc;
    sent = 0;
    while (sent < n_items) begin
      if (short_frames) len = $urandom_range(1, 2);
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(9, 20);
      else len = $urandom_range(1, 6);
      kind = frame_kind_t'($urandom_range(0, 3));
      base = $urandom_range(0, 15);
      for (int k = 0; k < len; k++) ring[k] = $urandom_range(0, cur_res - 1);
      for (int k = 0; k < len; k++) begin
        unique case (kind)
          FRAME_SPARSE: begin
            idx = dfd_pkg::INDEX_W'($urandom_range(0, cur_procs - 1));
            req = sparse_mask();
            alloc = sparse_mask();
          end
          FRAME_RING: begin
            // chain process k through resource ring[k+1]; the last row closes the loop unless its request is dropped
            idx = dfd_pkg::INDEX_W'((base + k) % cur_procs);
            alloc = dfd_pkg::MASK_W'(1) << ring[k];
            req = dfd_pkg::MASK_W'(1) << ring[(k + 1) % len];
            if (k == len - 1 && $urandom_range(0, 2) == 0) req = '0;
          end
          FRAME_DENSE: begin
            idx = dfd_pkg::INDEX_W'($urandom);
            req = dfd_pkg::MASK_W'($urandom);
            alloc = dfd_pkg::MASK_W'($urandom);
          end
          default: begin
            idx = dfd_pkg::INDEX_W'($urandom);
            req = sparse_mask() |
                  (dfd_pkg::MASK_W'($urandom) & ~dfd_pkg::MASK_W'((1 << cur_res) - 1));
            alloc = sparse_mask();
          end
        endcase
        send_row(idx, req, alloc, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    logic [dfd_pkg::COUNT_W-1:0] phase_procs [10] = '{16, 1, 4, 16, 1, 0, 0, 0, 8, 0};
    logic [dfd_pkg::COUNT_W-1:0] phase_res [10] = '{16, 1, 3, 1, 16, 31, 0, 0, 8, 0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    sender_idle = 0;
    receiver_idle = 0;
    hold_output = 0;
    cur_procs = 16;
    cur_res = 16;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // empty graph, self loop through one resource, two-process ring, open chain
    send_row(4'd0, 16'h0000, 16'h0000, 1'b1);
    send_row(4'd0, 16'h0001, 16'h0001, 1'b1);
    send_row(4'd0, 16'h0002, 16'h0001, 1'b0);
    send_row(4'd1, 16'h0001, 16'h0002, 1'b1);
    send_row(4'd0, 16'h0002, 16'h0001, 1'b0);
    send_row(4'd1, 16'h0000, 16'h0002, 1'b1);
    // full masks on the top row, then a dead end through all resources
    send_row(4'd15, 16'hffff, 16'hffff, 1'b1);
    send_row(4'd15, 16'hffff, 16'h0000, 1'b0);
    send_row(4'd0, 16'h0000, 16'hffff, 1'b1);
    // rows from the previous frame must be gone
    send_row(4'd3, 16'h0020, 16'h0000, 1'b1);

    set_counts(5'd2, 5'd2);
    send_row(4'd5, 16'h0001, 16'h0001, 1'b1);
    send_row(4'd0, 16'h0010, 16'h0010, 1'b1);
    send_row(4'd1, 16'h0002, 16'h0002, 1'b1);
    set_counts(5'd0, 5'd0);
    send_row(4'd0, 16'h0001, 16'h0001, 1'b1);
    send_row(4'd0, 16'h0002, 16'h0002, 1'b1);
    set_counts(5'd31, 5'd31);
    send_row(4'd15, 16'h8000, 16'h8000, 1'b1);
    send_row(4'd0, 16'h8000, 16'h8000, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 6 || ph == 7 || ph == 9) begin
        phase_procs[ph] = dfd_pkg::COUNT_W'($urandom_range(0, 31));
        phase_res[ph] = dfd_pkg::COUNT_W'($urandom_range(0, 31));
      end
      set_counts(phase_procs[ph], phase_res[ph]);
      sender_idle = (ph != 9) && (ph % 3 != 2);
      receiver_idle = (ph != 9) && (ph % 4 != 3);
      if (ph == 8) hold_output = 1;
      run_phase(144, ph == 8);
    end

    drain();
    if (mismatches == 0 && flags_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dfd_pkg.sv
design/dfd_front.sv
design/dfd_back.sv
design/deadlock_cycle_detector.sv
tb/deadlock_cycle_detector_checker.sv
tb/deadlock_cycle_detector_tb.sv
